[sv/trdz_pkg.sv]
// Shared types and constants for the radial thumbstick dead zone block.
// No dependencies; used by thumbstick_radial_dead_zone.
`default_nettype none

package trdz_pkg;

    // Register indexes on the configuration port.
    localparam logic [7:0] REG_LEFT_DZ  = 8'd0;
    localparam logic [7:0] REG_RIGHT_DZ = 8'd1;

    localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;

    // Full deflection, its square and its value in Q15.
    localparam logic [14:0] FULL_SCALE    = 15'd32767;
    localparam logic [31:0] FULL_SCALE_SQ = 32'd1073676289;
    localparam logic [30:0] FULL_SCALE_Q  = 31'd1073709056;

    // Iterations of each digit-serial unit in the pipeline.
    localparam int SQ_STEPS = 31;  // root of r^2 * 2^30, one bit each
    localparam int ND_STEPS = 16;  // normalized magnitude quotient bits
    localparam int AD_STEPS = 30;  // per-axis quotient bits of a^2 / r^2
    localparam int AS_STEPS = 15;  // per-axis root bits

    typedef struct packed {
        logic signed [15:0] stick_x;
        logic signed [15:0] stick_y;
        logic               is_left;
    } t_in;

    typedef struct packed {
        logic signed [15:0] scaled_x;
        logic signed [15:0] scaled_y;
        logic [14:0]        norm_magnitude;
        logic               in_dead_zone;
    } t_out;

    // Per-sample context that rides along the whole pipeline.
    typedef struct packed {
        logic [1:0]       neg;   // sign of x (0) and y (1)
        logic [1:0][16:0] mag;   // absolute values of x and y
        logic [14:0]      dz;
        logic [31:0]      r2;
        logic             dead;
        logic             big;
        logic [14:0]      span;
        logic [14:0]      norm;
    } t_ctx;

endpackage

`default_nettype wire

[sv/thumbstick_radial_dead_zone.sv]
// Radial dead zone with rescaling for a two-axis thumbstick sample.
// Throughput: one sample per cycle while the output is not stalled; the chain of
// digit-serial root and divide stages (31 + 16 + 30 + 15 steps) sets the depth,
// each step one register stage. A stalled output holds the whole pipeline.
// Reset clears all valid bits and loads the dead zone registers with 7849
// (left) and 8689 (right).
// Depends on trdz_pkg.
`default_nettype none

module thumbstick_radial_dead_zone (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire trdz_pkg::t_in i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output trdz_pkg::t_out    o_out_data,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [7:0]        i_cfg_index,
    input  wire  [14:0]       i_cfg_data
);

    logic        adv;
    logic [14:0] r_left_dz;
    logic [14:0] r_right_dz;

    assign o_cfg_ready = 1'b1;
    assign adv         = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= trdz_pkg::LEFT_DZ_RESET;
            r_right_dz <= trdz_pkg::RIGHT_DZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == trdz_pkg::REG_LEFT_DZ) begin
                r_left_dz <= i_cfg_data;
            end else if (i_cfg_index == trdz_pkg::REG_RIGHT_DZ) begin
                r_right_dz <= i_cfg_data;
            end
        end
    end

    // Stage A: magnitudes, signs and the selected dead zone.
    logic             r_a_v;
    trdz_pkg::t_ctx   r_a_ctx;
    trdz_pkg::t_ctx   n_a_ctx;

    always_comb begin
        n_a_ctx        = '0;
        n_a_ctx.neg[0] = i_in_data.stick_x[15];
        n_a_ctx.neg[1] = i_in_data.stick_y[15];
        n_a_ctx.mag[0] = i_in_data.stick_x[15] ? (17'd0 - {1'b1, i_in_data.stick_x})
                                               : {1'b0, i_in_data.stick_x};
        n_a_ctx.mag[1] = i_in_data.stick_y[15] ? (17'd0 - {1'b1, i_in_data.stick_y})
                                               : {1'b0, i_in_data.stick_y};
        n_a_ctx.dz     = i_in_data.is_left ? r_left_dz : r_right_dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_ctx <= n_a_ctx;
        end
    end

    // Stage B: squared radius and squared dead zone.
    logic             r_b_v;
    trdz_pkg::t_ctx   r_b_ctx;
    trdz_pkg::t_ctx   n_b_ctx;
    logic [29:0]      r_b_dz2;
    logic [33:0]      b_x2;
    logic [33:0]      b_y2;
    logic [29:0]      b_dz2;

    always_comb begin
        b_x2       = r_a_ctx.mag[0] * r_a_ctx.mag[0];
        b_y2       = r_a_ctx.mag[1] * r_a_ctx.mag[1];
        b_dz2      = r_a_ctx.dz * r_a_ctx.dz;
        n_b_ctx    = r_a_ctx;
        n_b_ctx.r2 = 32'(b_x2 + b_y2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_ctx <= n_b_ctx;
            r_b_dz2 <= b_dz2;
        end
    end

    // Radius root: floor(sqrt(r2 * 2^30)), two radicand bits per stage.
    logic           r_sq_v    [0:trdz_pkg::SQ_STEPS];
    trdz_pkg::t_ctx r_sq_ctx  [0:trdz_pkg::SQ_STEPS];
    logic [32:0]    r_sq_rem  [0:trdz_pkg::SQ_STEPS];
    logic [30:0]    r_sq_root [0:trdz_pkg::SQ_STEPS];
    logic [31:0]    r_sq_src  [0:trdz_pkg::SQ_STEPS];
    trdz_pkg::t_ctx n_sq_ctx;

    always_comb begin
        n_sq_ctx      = r_b_ctx;
        n_sq_ctx.dead = (r_b_ctx.r2 <= {2'b00, r_b_dz2});
        n_sq_ctx.big  = (r_b_ctx.r2 >= trdz_pkg::FULL_SCALE_SQ);
        n_sq_ctx.span = trdz_pkg::FULL_SCALE - r_b_ctx.dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_ctx[0]  <= n_sq_ctx;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_src[0]  <= r_b_ctx.r2;
        end
    end

    for (genvar k = 0; k < trdz_pkg::SQ_STEPS; k++) begin : g_sq
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic        ge;

        always_comb begin
            rem_sh = {r_sq_rem[k][31:0], r_sq_src[k][31:30]};
            trial  = {1'b0, r_sq_root[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_ctx[k+1]  <= r_sq_ctx[k];
                r_sq_src[k+1]  <= {r_sq_src[k][29:0], 2'b00};
                r_sq_rem[k+1]  <= ge ? 33'(rem_sh - trial) : rem_sh[32:0];
                r_sq_root[k+1] <= {r_sq_root[k][29:0], ge};
            end
        end
    end

    // Normalized magnitude: (s - dz * 2^15) / span, restoring, one bit per stage.
    logic           r_nd_v   [0:trdz_pkg::ND_STEPS];
    trdz_pkg::t_ctx r_nd_ctx [0:trdz_pkg::ND_STEPS];
    logic [14:0]    r_nd_rem [0:trdz_pkg::ND_STEPS];
    logic [15:0]    r_nd_low [0:trdz_pkg::ND_STEPS];
    logic [15:0]    r_nd_q   [0:trdz_pkg::ND_STEPS];
    logic [30:0]    nd_s;
    logic [30:0]    nd_num;

    always_comb begin
        nd_s   = r_sq_ctx[trdz_pkg::SQ_STEPS].big ? trdz_pkg::FULL_SCALE_Q
                                                  : r_sq_root[trdz_pkg::SQ_STEPS];
        nd_num = nd_s - {1'b0, r_sq_ctx[trdz_pkg::SQ_STEPS].dz, 15'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd_v[0] <= 1'b0;
        end else if (adv) begin
            r_nd_v[0] <= r_sq_v[trdz_pkg::SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nd_ctx[0] <= r_sq_ctx[trdz_pkg::SQ_STEPS];
            r_nd_rem[0] <= nd_num[30:16];
            r_nd_low[0] <= nd_num[15:0];
            r_nd_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < trdz_pkg::ND_STEPS; k++) begin : g_nd
        logic [15:0] rem_sh;
        logic [15:0] dvs;
        logic        ge;

        always_comb begin
            rem_sh = {r_nd_rem[k], r_nd_low[k][15]};
            dvs    = {1'b0, r_nd_ctx[k].span};
            ge     = (rem_sh >= dvs);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nd_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_nd_v[k+1] <= r_nd_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_nd_ctx[k+1] <= r_nd_ctx[k];
                r_nd_low[k+1] <= {r_nd_low[k][14:0], 1'b0};
                r_nd_rem[k+1] <= ge ? 15'(rem_sh - dvs) : rem_sh[14:0];
                r_nd_q[k+1]   <= {r_nd_q[k][14:0], ge};
            end
        end
    end

    // Stage M: saturate the quotient; a zero span gives no magnitude.
    logic           r_m_v;
    trdz_pkg::t_ctx r_m_ctx;
    trdz_pkg::t_ctx n_m_ctx;
    logic [14:0]    m_norm;

    always_comb begin
        if (r_nd_ctx[trdz_pkg::ND_STEPS].span == 15'd0) begin
            m_norm = '0;
        end else if (r_nd_q[trdz_pkg::ND_STEPS][15]) begin
            m_norm = trdz_pkg::FULL_SCALE;
        end else begin
            m_norm = r_nd_q[trdz_pkg::ND_STEPS][14:0];
        end
        n_m_ctx      = r_nd_ctx[trdz_pkg::ND_STEPS];
        n_m_ctx.norm = m_norm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= r_nd_v[trdz_pkg::ND_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_ctx <= n_m_ctx;
        end
    end

    // Stage P: each axis magnitude times the normalized magnitude.
    logic             r_p_v;
    trdz_pkg::t_ctx   r_p_ctx;
    logic [1:0][29:0] r_p_a;
    logic [1:0][31:0] p_prod;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            p_prod[i] = r_m_ctx.mag[i] * r_m_ctx.norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (adv) begin
            r_p_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_ctx <= r_m_ctx;
            for (int i = 0; i < 2; i++) begin
                r_p_a[i] <= p_prod[i][29:0];
            end
        end
    end

    // Per-axis divide: floor(a^2 / r2), one quotient bit per stage.
    logic             r_ad_v   [0:trdz_pkg::AD_STEPS];
    trdz_pkg::t_ctx   r_ad_ctx [0:trdz_pkg::AD_STEPS];
    logic [1:0][31:0] r_ad_rem [0:trdz_pkg::AD_STEPS];
    logic [1:0][29:0] r_ad_low [0:trdz_pkg::AD_STEPS];
    logic [1:0][29:0] r_ad_q   [0:trdz_pkg::AD_STEPS];
    logic [1:0][59:0] ad_sq;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            ad_sq[i] = r_p_a[i] * r_p_a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ad_v[0] <= 1'b0;
        end else if (adv) begin
            r_ad_v[0] <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ad_ctx[0] <= r_p_ctx;
            for (int i = 0; i < 2; i++) begin
                r_ad_rem[0][i] <= {2'b00, ad_sq[i][59:30]};
                r_ad_low[0][i] <= ad_sq[i][29:0];
                r_ad_q[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < trdz_pkg::AD_STEPS; k++) begin : g_ad
        logic [1:0][32:0] rem_sh;
        logic [1:0]       ge;
        logic [32:0]      dvs;

        always_comb begin
            dvs = {1'b0, r_ad_ctx[k].r2};
            for (int i = 0; i < 2; i++) begin
                rem_sh[i] = {r_ad_rem[k][i], r_ad_low[k][i][29]};
                ge[i]     = (rem_sh[i] >= dvs);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ad_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_ad_v[k+1] <= r_ad_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_ad_ctx[k+1] <= r_ad_ctx[k];
                for (int i = 0; i < 2; i++) begin
                    r_ad_low[k+1][i] <= {r_ad_low[k][i][28:0], 1'b0};
                    r_ad_rem[k+1][i] <= ge[i] ? 32'(rem_sh[i] - dvs) : rem_sh[i][31:0];
                    r_ad_q[k+1][i]   <= {r_ad_q[k][i][28:0], ge[i]};
                end
            end
        end
    end

    // Per-axis root of the quotient, which equals floor(a / r).
    logic             r_as_v    [0:trdz_pkg::AS_STEPS];
    trdz_pkg::t_ctx   r_as_ctx  [0:trdz_pkg::AS_STEPS];
    logic [1:0][16:0] r_as_rem  [0:trdz_pkg::AS_STEPS];
    logic [1:0][14:0] r_as_root [0:trdz_pkg::AS_STEPS];
    logic [1:0][29:0] r_as_src  [0:trdz_pkg::AS_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as_v[0] <= 1'b0;
        end else if (adv) begin
            r_as_v[0] <= r_ad_v[trdz_pkg::AD_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_as_ctx[0]  <= r_ad_ctx[trdz_pkg::AD_STEPS];
            r_as_src[0]  <= r_ad_q[trdz_pkg::AD_STEPS];
            r_as_rem[0]  <= '0;
            r_as_root[0] <= '0;
        end
    end

    for (genvar k = 0; k < trdz_pkg::AS_STEPS; k++) begin : g_as
        logic [1:0][17:0] rem_sh;
        logic [1:0][17:0] trial;
        logic [1:0]       ge;

        always_comb begin
            for (int i = 0; i < 2; i++) begin
                rem_sh[i] = {r_as_rem[k][i][15:0], r_as_src[k][i][29:28]};
                trial[i]  = {1'b0, r_as_root[k][i], 2'b01};
                ge[i]     = (rem_sh[i] >= trial[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_as_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_as_v[k+1] <= r_as_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_as_ctx[k+1] <= r_as_ctx[k];
                for (int i = 0; i < 2; i++) begin
                    r_as_src[k+1][i]  <= {r_as_src[k][i][27:0], 2'b00};
                    r_as_rem[k+1][i]  <= ge[i] ? 17'(rem_sh[i] - trial[i])
                                               : rem_sh[i][16:0];
                    r_as_root[k+1][i] <= {r_as_root[k][i][13:0], ge[i]};
                end
            end
        end
    end

    // Output register: apply signs and the dead zone.
    trdz_pkg::t_ctx   out_ctx;
    logic [1:0][15:0] out_axis;
    trdz_pkg::t_out   n_out;

    always_comb begin
        out_ctx = r_as_ctx[trdz_pkg::AS_STEPS];
        for (int i = 0; i < 2; i++) begin
            out_axis[i] = out_ctx.neg[i]
                        ? (16'd0 - {1'b0, r_as_root[trdz_pkg::AS_STEPS][i]})
                        : {1'b0, r_as_root[trdz_pkg::AS_STEPS][i]};
        end
        n_out = '0;
        n_out.in_dead_zone = out_ctx.dead;
        if (!out_ctx.dead) begin
            n_out.scaled_x       = out_axis[0];
            n_out.scaled_y       = out_axis[1];
            n_out.norm_magnitude = out_ctx.norm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= r_as_v[trdz_pkg::AS_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_data <= n_out;
        end
    end

`ifndef SYNTHESIS
    // A dead zone result yields no magnitude and no deflection.
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.in_dead_zone |->
            o_out_data.norm_magnitude == 15'd0 && o_out_data.scaled_x == 16'sd0
            && o_out_data.scaled_y == 16'sd0)
        else $error("dead zone result carries a nonzero field");

    // An axis never exceeds the normalized magnitude of its sample.
    a_axis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            $signed(o_out_data.scaled_x) <= $signed({1'b0, o_out_data.norm_magnitude})
            && $signed(o_out_data.scaled_x) >= -$signed({1'b0, o_out_data.norm_magnitude})
            && $signed(o_out_data.scaled_y) <= $signed({1'b0, o_out_data.norm_magnitude})
            && $signed(o_out_data.scaled_y) >= -$signed({1'b0, o_out_data.norm_magnitude}))
        else $error("axis output exceeds normalized magnitude");

    // Nothing leaves the pipeline right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid directly after reset");
`endif

endmodule

`default_nettype wire
